FILE: rtl/idfl_pkg.sv
// Package for the free-list id allocator: sizes, link marks, codes and the
// controller/datapath command and status types. No dependencies.
package idfl_pkg;

	localparam int DEPTH     = 1024;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int LINK_W    = $clog2(DEPTH + 2);
	localparam int ID_W      = 32;
	localparam int ACT_W     = 2;
	localparam int STAT_W    = 3;
	localparam int CFG_IDX_W = 1;

	localparam logic [LINK_W-1:0] LINK_END   = LINK_W'(DEPTH);
	localparam logic [LINK_W-1:0] LINK_TAKEN = LINK_W'(DEPTH + 1);
	localparam logic [ID_W-1:0]   NO_ID      = '1;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_ID = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ID = CFG_IDX_W'(1);

	localparam logic [ID_W-1:0] MIN_RST = 32'd0;
	localparam logic [ID_W-1:0] MAX_RST = 32'd1023;
	localparam longint SPAN_RST = longint'(MAX_RST) - longint'(MIN_RST) + 64'sd1;
	localparam longint POOL_RST_L = (MAX_RST < MIN_RST) ? 64'sd0 :
		((SPAN_RST > longint'(DEPTH)) ? longint'(DEPTH) : SPAN_RST);
	localparam logic [CNT_W-1:0] POOL_RST = CNT_W'(POOL_RST_L);

	typedef enum logic [ACT_W-1:0] {
		ACT_ALLOC   = 2'd0,
		ACT_RESERVE = 2'd1,
		ACT_FREE    = 2'd2,
		ACT_QUERY   = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		STS_OK        = 3'd0,
		STS_EXHAUSTED = 3'd1,
		STS_RANGE     = 3'd2,
		STS_NOT_ALLOC = 3'd3,
		STS_TAKEN     = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_SWEEP,
		OP_LATCH,
		OP_CHECK,
		OP_READ,
		OP_EVAL,
		OP_FREE_TAIL,
		OP_FREE_MARK,
		OP_SRCH_RD,
		OP_SRCH_CMP,
		OP_MARK,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic    cfg_wr;
		logic    sweep_last;
		action_t action;
		logic    bad;
		logic    rd_taken;
		logic    avail_one;
		logic    head_is_slot;
		logic    slot_zero;
		logic    up_ok;
		logic    hit;
		logic    dir_up;
		logic    ptr_zero;
		logic    ptr_up_end;
		logic    out_busy;
	} sts_t;

endpackage

FILE: rtl/idfl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module idfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/idfl_ctrl.sv
// Allocator controller: sequences rebuild sweep, request decode, chain walk
// and result hand-off. Depends on idfl_pkg.
module idfl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  idfl_pkg::sts_t sts,
	output idfl_pkg::cmd_t cmd
);

	typedef enum logic [10:0] {
		ST_INIT      = 11'b000_0000_0001,
		ST_IDLE      = 11'b000_0000_0010,
		ST_CHECK     = 11'b000_0000_0100,
		ST_READ      = 11'b000_0000_1000,
		ST_EVAL      = 11'b000_0001_0000,
		ST_FREE_TAIL = 11'b000_0010_0000,
		ST_FREE_MARK = 11'b000_0100_0000,
		ST_SRCH_RD   = 11'b000_1000_0000,
		ST_SRCH_CMP  = 11'b001_0000_0000,
		ST_MARK      = 11'b010_0000_0000,
		ST_FIN       = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = idfl_pkg::OP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cmd.op = idfl_pkg::OP_SWEEP;
				if (sts.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = idfl_pkg::OP_LATCH;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.op  = idfl_pkg::OP_CHECK;
				state_d = ST_READ;
			end
			ST_READ: begin
				cmd.op  = idfl_pkg::OP_READ;
				state_d = sts.bad ? ST_FIN : ST_EVAL;
			end
			ST_EVAL: begin
				cmd.op = idfl_pkg::OP_EVAL;
				unique case (sts.action)
					idfl_pkg::ACT_ALLOC,
					idfl_pkg::ACT_QUERY: state_d = ST_FIN;
					idfl_pkg::ACT_FREE: state_d = sts.rd_taken ? ST_FREE_TAIL : ST_FIN;
					idfl_pkg::ACT_RESERVE: begin
						if (sts.rd_taken) begin
							state_d = ST_FIN;
						end else if (sts.avail_one || sts.head_is_slot) begin
							state_d = ST_MARK;
						end else if (!sts.slot_zero || sts.up_ok) begin
							state_d = ST_SRCH_RD;
						end else begin
							state_d = ST_MARK;
						end
					end
					default: state_d = ST_FIN;
				endcase
			end
			ST_FREE_TAIL: begin
				cmd.op  = idfl_pkg::OP_FREE_TAIL;
				state_d = ST_FREE_MARK;
			end
			ST_FREE_MARK: begin
				cmd.op  = idfl_pkg::OP_FREE_MARK;
				state_d = ST_FIN;
			end
			ST_SRCH_RD: begin
				cmd.op  = idfl_pkg::OP_SRCH_RD;
				state_d = ST_SRCH_CMP;
			end
			ST_SRCH_CMP: begin
				cmd.op = idfl_pkg::OP_SRCH_CMP;
				if (sts.hit) begin
					state_d = ST_MARK;
				end else if (!sts.dir_up) begin
					state_d = (!sts.ptr_zero || sts.up_ok) ? ST_SRCH_RD : ST_MARK;
				end else begin
					state_d = sts.ptr_up_end ? ST_MARK : ST_SRCH_RD;
				end
			end
			ST_MARK: begin
				cmd.op  = idfl_pkg::OP_MARK;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!sts.out_busy) begin
					cmd.op  = idfl_pkg::OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
		if (sts.cfg_wr) begin
			state_d = ST_INIT;
		end
	end

endmodule

FILE: rtl/idfl_dp.sv
// Allocator datapath: range registers, chain pointers, link table RAM and
// the result register. Depends on idfl_pkg and idfl_ram.
module idfl_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [idfl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [idfl_pkg::ID_W-1:0]         cfg_data,
	input  logic [idfl_pkg::ACT_W-1:0]        action,
	input  logic [idfl_pkg::ID_W-1:0]         req_id,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [idfl_pkg::ID_W-1:0]         result_id,
	output logic [idfl_pkg::STAT_W-1:0]       status,
	output logic                              is_taken,
	output logic [idfl_pkg::CNT_W-1:0]        used_count,
	output logic [idfl_pkg::CNT_W-1:0]        free_count,
	input  idfl_pkg::cmd_t                    cmd,
	output idfl_pkg::sts_t                    sts
);

	localparam int IDX_W  = idfl_pkg::IDX_W;
	localparam int CNT_W  = idfl_pkg::CNT_W;
	localparam int LINK_W = idfl_pkg::LINK_W;
	localparam int ID_W   = idfl_pkg::ID_W;

	logic [ID_W-1:0]   min_q, max_q, req_q, res_q;
	logic [CNT_W-1:0]  pool_q, avail_q;
	logic [LINK_W-1:0] head_q, link_q;
	logic [IDX_W-1:0]  tail_q, slot_q, ptr_q;
	idfl_pkg::action_t act_q;
	idfl_pkg::status_t stat_q;
	logic              taken_q, rng_q, exh_q, dir_q;

	logic [ID_W-1:0]        res_out_q;
	logic [idfl_pkg::STAT_W-1:0] stat_out_q;
	logic                   taken_out_q, out_valid_q;
	logic [CNT_W-1:0]       used_out_q, free_out_q;

	logic              cfg_wr;
	logic [ID_W-1:0]   min_d, max_d, offset;
	logic [ID_W:0]     span;
	logic [CNT_W-1:0]  pool_d, ptr_inc, slot_inc;
	logic              rd_taken;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr, ram_raddr;
	logic [LINK_W-1:0] ram_wdata, rdata;

	assign cfg_wr = cfg_we && (cfg_index == idfl_pkg::REG_MIN_ID ||
		cfg_index == idfl_pkg::REG_MAX_ID);
	assign min_d = (cfg_we && cfg_index == idfl_pkg::REG_MIN_ID) ? cfg_data : min_q;
	assign max_d = (cfg_we && cfg_index == idfl_pkg::REG_MAX_ID) ? cfg_data : max_q;
	assign span  = {1'b0, max_d} - {1'b0, min_d} + (ID_W+1)'(1);

	always_comb begin
		if (max_d < min_d) begin
			pool_d = '0;
		end else if (span > (ID_W+1)'(idfl_pkg::DEPTH)) begin
			pool_d = CNT_W'(idfl_pkg::DEPTH);
		end else begin
			pool_d = span[CNT_W-1:0];
		end
	end

	assign offset   = req_q - min_q;
	assign ptr_inc  = CNT_W'(ptr_q) + CNT_W'(1);
	assign slot_inc = CNT_W'(slot_q) + CNT_W'(1);
	assign rd_taken = (rdata == idfl_pkg::LINK_TAKEN);

	always_comb begin
		sts.cfg_wr       = cfg_wr;
		sts.sweep_last   = (ptr_q == IDX_W'(idfl_pkg::DEPTH - 1));
		sts.action       = act_q;
		sts.bad          = (act_q == idfl_pkg::ACT_ALLOC) ? exh_q : !rng_q;
		sts.rd_taken     = rd_taken;
		sts.avail_one    = (avail_q == CNT_W'(1));
		sts.head_is_slot = (head_q == LINK_W'(slot_q));
		sts.slot_zero    = (slot_q == '0);
		sts.up_ok        = (slot_inc < pool_q);
		sts.hit          = (rdata == LINK_W'(slot_q));
		sts.dir_up       = dir_q;
		sts.ptr_zero     = (ptr_q == '0);
		sts.ptr_up_end   = (ptr_inc >= pool_q);
		sts.out_busy     = out_valid_q && !out_ready;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = idfl_pkg::LINK_TAKEN;
		ram_raddr = ptr_q;
		unique case (cmd.op)
			idfl_pkg::OP_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q;
				ram_wdata = (ptr_inc < pool_q) ? LINK_W'(ptr_inc) : idfl_pkg::LINK_END;
			end
			idfl_pkg::OP_READ: begin
				ram_raddr = (act_q == idfl_pkg::ACT_ALLOC) ? head_q[IDX_W-1:0] : slot_q;
			end
			idfl_pkg::OP_EVAL: begin
				if (act_q == idfl_pkg::ACT_ALLOC) begin
					ram_we    = 1'b1;
					ram_waddr = head_q[IDX_W-1:0];
				end
			end
			idfl_pkg::OP_FREE_TAIL: begin
				ram_we    = (head_q != idfl_pkg::LINK_END) && (CNT_W'(tail_q) < pool_q);
				ram_waddr = tail_q;
				ram_wdata = LINK_W'(slot_q);
			end
			idfl_pkg::OP_FREE_MARK: begin
				ram_we    = 1'b1;
				ram_wdata = idfl_pkg::LINK_END;
			end
			idfl_pkg::OP_SRCH_CMP: begin
				ram_we    = sts.hit;
				ram_waddr = ptr_q;
				ram_wdata = link_q;
			end
			idfl_pkg::OP_MARK: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	idfl_ram #(
		.WIDTH(LINK_W),
		.DEPTH(idfl_pkg::DEPTH)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= idfl_pkg::MIN_RST;
			max_q   <= idfl_pkg::MAX_RST;
			pool_q  <= idfl_pkg::POOL_RST;
			avail_q <= idfl_pkg::POOL_RST;
			head_q  <= (idfl_pkg::POOL_RST != '0) ? '0 : idfl_pkg::LINK_END;
			tail_q  <= (idfl_pkg::POOL_RST != '0) ?
				IDX_W'(idfl_pkg::POOL_RST - CNT_W'(1)) : '0;
			ptr_q   <= '0;
			dir_q   <= 1'b0;
		end else if (cfg_wr) begin
			min_q   <= min_d;
			max_q   <= max_d;
			pool_q  <= pool_d;
			avail_q <= pool_d;
			head_q  <= (pool_d != '0) ? '0 : idfl_pkg::LINK_END;
			tail_q  <= (pool_d != '0) ? IDX_W'(pool_d - CNT_W'(1)) : '0;
			ptr_q   <= '0;
		end else begin
			unique case (cmd.op)
				idfl_pkg::OP_SWEEP: begin
					ptr_q <= sts.sweep_last ? '0 : IDX_W'(ptr_inc);
				end
				idfl_pkg::OP_EVAL: begin
					if (act_q == idfl_pkg::ACT_ALLOC) begin
						head_q  <= rdata;
						avail_q <= avail_q - CNT_W'(1);
					end else if (act_q == idfl_pkg::ACT_RESERVE && !rd_taken) begin
						if (sts.avail_one) begin
							head_q <= idfl_pkg::LINK_END;
						end else if (sts.head_is_slot) begin
							head_q <= rdata;
						end
						ptr_q <= sts.slot_zero ? IDX_W'(slot_inc) : slot_q - IDX_W'(1);
						dir_q <= sts.slot_zero;
					end
				end
				idfl_pkg::OP_FREE_MARK: begin
					tail_q  <= slot_q;
					avail_q <= avail_q + CNT_W'(1);
					if (head_q == idfl_pkg::LINK_END) begin
						head_q <= LINK_W'(slot_q);
					end
				end
				idfl_pkg::OP_SRCH_CMP: begin
					if (sts.hit) begin
						if (tail_q == slot_q) begin
							tail_q <= ptr_q;
						end
					end else if (!dir_q) begin
						if (sts.ptr_zero) begin
							ptr_q <= IDX_W'(slot_inc);
							dir_q <= 1'b1;
						end else begin
							ptr_q <= ptr_q - IDX_W'(1);
						end
					end else begin
						ptr_q <= IDX_W'(ptr_inc);
					end
				end
				idfl_pkg::OP_MARK: begin
					if (avail_q != '0) begin
						avail_q <= avail_q - CNT_W'(1);
					end
				end
				default: begin
					ptr_q <= ptr_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			idfl_pkg::OP_LATCH: begin
				act_q   <= idfl_pkg::action_t'(action);
				req_q   <= req_id;
				res_q   <= idfl_pkg::NO_ID;
				stat_q  <= idfl_pkg::STS_OK;
				taken_q <= 1'b0;
			end
			idfl_pkg::OP_CHECK: begin
				rng_q  <= (req_q >= min_q) && (offset < ID_W'(pool_q));
				slot_q <= offset[IDX_W-1:0];
				exh_q  <= (head_q >= LINK_W'(pool_q)) || (avail_q == '0);
			end
			idfl_pkg::OP_READ: begin
				if (act_q == idfl_pkg::ACT_ALLOC) begin
					if (exh_q) begin
						stat_q <= idfl_pkg::STS_EXHAUSTED;
					end
				end else if (!rng_q) begin
					stat_q <= idfl_pkg::STS_RANGE;
				end
			end
			idfl_pkg::OP_EVAL: begin
				link_q <= rdata;
				unique case (act_q)
					idfl_pkg::ACT_ALLOC: res_q <= min_q + ID_W'(head_q);
					idfl_pkg::ACT_QUERY: taken_q <= rd_taken;
					idfl_pkg::ACT_FREE: begin
						if (!rd_taken) begin
							stat_q <= idfl_pkg::STS_NOT_ALLOC;
						end
					end
					idfl_pkg::ACT_RESERVE: begin
						if (rd_taken) begin
							stat_q <= idfl_pkg::STS_TAKEN;
						end
					end
					default: taken_q <= 1'b0;
				endcase
			end
			idfl_pkg::OP_MARK: begin
				res_q <= req_q;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == idfl_pkg::OP_OUT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == idfl_pkg::OP_OUT) begin
			res_out_q   <= res_q;
			stat_out_q  <= stat_q;
			taken_out_q <= taken_q;
			used_out_q  <= pool_q - avail_q;
			free_out_q  <= avail_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign result_id  = res_out_q;
	assign status     = stat_out_q;
	assign is_taken   = taken_out_q;
	assign used_count = used_out_q;
	assign free_count = free_out_q;

endmodule

FILE: rtl/id_free_list_allocator_top.sv
// Top level of the free-list id allocator: controller plus datapath.
// Depends on idfl_pkg, idfl_ctrl, idfl_dp.
//
//  channel   handshake               payload
//  in        in_valid / in_ready     action, req_id
//  out       out_valid / out_ready   result_id, status, is_taken, used_count, free_count
//  cfg       cfg_we                  cfg_index, cfg_data
//
// An item is latched, checked and read from the link table. Allocate and query then
// finish; free of a taken id links it behind the tail and marks it the end; reserve
// may search its predecessor down, then up, over at most DEPTH - 1 link entries. An
// item rejected for range or exhaustion skips these steps. The table is rebuilt after
// reset and after every configuration write, one entry a cycle, with in_ready low.
// A finished result waits in the output register; the next item holds in its last step.
module id_free_list_allocator_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [idfl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [idfl_pkg::ID_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [idfl_pkg::ACT_W-1:0]     action,
	input  logic [idfl_pkg::ID_W-1:0]      req_id,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [idfl_pkg::ID_W-1:0]      result_id,
	output logic [idfl_pkg::STAT_W-1:0]    status,
	output logic                           is_taken,
	output logic [idfl_pkg::CNT_W-1:0]     used_count,
	output logic [idfl_pkg::CNT_W-1:0]     free_count
);

	idfl_pkg::cmd_t cmd;
	idfl_pkg::sts_t sts;

	idfl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	idfl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.action    (action),
		.req_id    (req_id),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result_id (result_id),
		.status    (status),
		.is_taken  (is_taken),
		.used_count(used_count),
		.free_count(free_count),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

FILE: rtl/idfl_checker.sv
// Port-level checker for the free-list id allocator, bound to the top level.
// Depends on idfl_pkg and id_free_list_allocator_top.
module idfl_assertions (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [idfl_pkg::ID_W-1:0]      result_id,
	input logic [idfl_pkg::STAT_W-1:0]    status,
	input logic                           is_taken,
	input logic [idfl_pkg::CNT_W-1:0]     used_count,
	input logic [idfl_pkg::CNT_W-1:0]     free_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_id) && $stable(status))
		else $error("result changed while stalled");

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, used_count} + {1'b0, free_count}) <=
			(idfl_pkg::CNT_W+1)'(idfl_pkg::DEPTH))
		else $error("used plus free exceeds pool");

	a_fail_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != idfl_pkg::STS_OK |-> result_id == idfl_pkg::NO_ID)
		else $error("failed action returned an id");

	a_taken_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_taken |-> status == idfl_pkg::STS_OK)
		else $error("taken flag on failed action");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transfer accepted back to back");

endmodule

bind id_free_list_allocator_top idfl_assertions u_idfl_assertions (.*);

FILE: tb/idfl_checker.sv
`timescale 1ns / 1ps
// Checker for the free-list id allocator: mirrors the pool, the link chain and the
// counters, and compares every output transfer with the predicted reply.
// Depends on idfl_pkg.
module idfl_checker
	import idfl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ID_W-1:0]      cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [ACT_W-1:0]     action,
	input  logic [ID_W-1:0]      req_id,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [ID_W-1:0]      result_id,
	input  logic [STAT_W-1:0]    status,
	input  logic                 is_taken,
	input  logic [CNT_W-1:0]     used_count,
	input  logic [CNT_W-1:0]     free_count,
	output int                   errors,
	output int                   replies_due
);

	typedef struct {
		logic [ID_W-1:0]  id;
		status_t          st;
		logic             taken;
		logic [CNT_W-1:0] used;
		logic [CNT_W-1:0] avail;
	} reply_t;

	logic [ID_W-1:0]   lo_id;
	logic [ID_W-1:0]   hi_id;
	logic [CNT_W-1:0]  pool_len;
	logic [CNT_W-1:0]  free_left;
	logic [LINK_W-1:0] chain [DEPTH];
	logic [LINK_W-1:0] first_free;
	logic [IDX_W-1:0]  last_free;
	reply_t            pending_replies [$];

	task automatic lay_chain();
		logic [ID_W:0] span;
		if (hi_id < lo_id) begin
			pool_len = '0;
		end else begin
			span = {1'b0, hi_id} - {1'b0, lo_id} + 1'b1;
			pool_len = (span > DEPTH) ? CNT_W'(DEPTH) : span[CNT_W-1:0];
		end
		for (int i = 0; i < DEPTH; i++)
			chain[i] = (i + 1 < pool_len) ? LINK_W'(i + 1) : LINK_END;
		first_free = (pool_len != 0) ? '0 : LINK_END;
		last_free  = (pool_len != 0) ? IDX_W'(pool_len - 1'b1) : '0;
		free_left  = pool_len;
	endtask

	function automatic bit locate(input logic [ID_W-1:0] id, output logic [IDX_W-1:0] slot);
		logic [ID_W-1:0] off;
		slot = '0;
		if (id < lo_id)
			return 1'b0;
		off = id - lo_id;
		if (off >= ID_W'(pool_len))
			return 1'b0;
		slot = off[IDX_W-1:0];
		return 1'b1;
	endfunction

	// Unlink a free slot: predecessor is searched downward first, then upward.
	function automatic void take_out(input logic [IDX_W-1:0] slot);
		int p;
		int q;
		bit found;
		found = 1'b0;
		if (free_left == 1) begin
			first_free = LINK_END;
		end else if (first_free == LINK_W'(slot)) begin
			first_free = chain[slot];
		end else begin
			p = slot;
			while (p > 0 && !found) begin
				if (chain[p-1] == LINK_W'(slot))
					found = 1'b1;
				p = p - 1;
			end
			if (!found) begin
				q = slot + 1;
				while (q < pool_len && !found) begin
					if (chain[q] == LINK_W'(slot))
						found = 1'b1;
					else
						q++;
				end
				p = q;
			end
			if (found) begin
				chain[p] = chain[slot];
				if (last_free == slot)
					last_free = p[IDX_W-1:0];
			end
		end
		chain[slot] = LINK_TAKEN;
		if (free_left != 0)
			free_left = free_left - 1'b1;
	endfunction

	function automatic reply_t serve_request(input action_t act, input logic [ID_W-1:0] id);
		reply_t r;
		logic [IDX_W-1:0] slot;
		bit hit;
		r.id    = NO_ID;
		r.st    = STS_OK;
		r.taken = 1'b0;
		hit = locate(id, slot);
		case (act)
			ACT_ALLOC: begin
				if (first_free >= pool_len || free_left == 0) begin
					r.st = STS_EXHAUSTED;
				end else begin
					slot = first_free[IDX_W-1:0];
					first_free = chain[slot];
					chain[slot] = LINK_TAKEN;
					free_left = free_left - 1'b1;
					r.id = ID_W'(slot) + lo_id;
				end
			end
			ACT_RESERVE: begin
				if (!hit) begin
					r.st = STS_RANGE;
				end else if (chain[slot] == LINK_TAKEN) begin
					r.st = STS_TAKEN;
				end else begin
					take_out(slot);
					r.id = id;
				end
			end
			ACT_FREE: begin
				if (!hit) begin
					r.st = STS_RANGE;
				end else if (chain[slot] != LINK_TAKEN) begin
					r.st = STS_NOT_ALLOC;
				end else begin
					if (first_free != LINK_END && last_free < pool_len)
						chain[last_free] = LINK_W'(slot);
					chain[slot] = LINK_END;
					last_free = slot;
					if (first_free == LINK_END)
						first_free = LINK_W'(slot);
					free_left = free_left + 1'b1;
				end
			end
			default: begin
				if (!hit)
					r.st = STS_RANGE;
				else
					r.taken = (chain[slot] == LINK_TAKEN);
			end
		endcase
		r.used  = pool_len - free_left;
		r.avail = free_left;
		return r;
	endfunction

	task automatic check_reply(input reply_t want);
		bit bad;
		bad = 1'b0;
		if (result_id !== want.id) begin
			bad = 1'b1;
			if (errors < 30)
				$error("result_id: expected %h, got %h", want.id, result_id);
		end
		if (status !== want.st) begin
			bad = 1'b1;
			if (errors < 30)
				$error("status: expected %0d, got %0d", want.st, status);
		end
		if (is_taken !== want.taken) begin
			bad = 1'b1;
			if (errors < 30)
				$error("is_taken: expected %0d, got %0d", want.taken, is_taken);
		end
		if (used_count !== want.used) begin
			bad = 1'b1;
			if (errors < 30)
				$error("used_count: expected %0d, got %0d", want.used, used_count);
		end
		if (free_count !== want.avail) begin
			bad = 1'b1;
			if (errors < 30)
				$error("free_count: expected %0d, got %0d", want.avail, free_count);
		end
		if (bad)
			errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_id = MIN_RST;
			hi_id = MAX_RST;
			lay_chain();
			pending_replies.delete();
			errors = 0;
			replies_due = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_replies.size() == 0) begin
					if (errors < 30)
						$error("output transfer with no reply pending: result_id %h status %0d",
							result_id, status);
					errors++;
				end else begin
					check_reply(pending_replies.pop_front());
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_MIN_ID: lo_id = cfg_data;
					REG_MAX_ID: hi_id = cfg_data;
					default: ;
				endcase
				lay_chain();
			end
			if (in_valid && in_ready)
				pending_replies.push_back(serve_request(action_t'(action), req_id));
			replies_due = pending_replies.size();
		end
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the free-list id allocator: clock, reset, stimulus, watchdog
// and verdict. Depends on idfl_pkg, id_free_list_allocator_top and idfl_checker.
module tb_top;
	import idfl_pkg::*;

	localparam int WATCH_LIMIT = 40000;
	localparam int HOLD_CYCLES = 400;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ID_W-1:0]      cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic [ACT_W-1:0]     action    = '0;
	logic [ID_W-1:0]      req_id    = '0;
	logic                 out_ready = 1'b0;
	logic                 in_ready;
	logic                 out_valid;
	logic [ID_W-1:0]      result_id;
	logic [STAT_W-1:0]    status;
	logic                 is_taken;
	logic [CNT_W-1:0]     used_count;
	logic [CNT_W-1:0]     free_count;

	int              errors;
	int              replies_due;
	int              idle_cycles = 0;
	bit              tx_steady   = 1'b0;
	bit              rx_steady   = 1'b0;
	bit              hold_req    = 1'b0;
	bit              hold_done   = 1'b0;
	logic [ID_W-1:0] pool_lo     = MIN_RST;
	int              pool_len    = DEPTH;

	id_free_list_allocator_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.req_id     (req_id),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result_id  (result_id),
		.status     (status),
		.is_taken   (is_taken),
		.used_count (used_count),
		.free_count (free_count)
	);

	idfl_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.req_id      (req_id),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_id   (result_id),
		.status      (status),
		.is_taken    (is_taken),
		.used_count  (used_count),
		.free_count  (free_count),
		.errors      (errors),
		.replies_due (replies_due)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_item(input action_t act, input logic [ID_W-1:0] id);
		int g;
		g = tx_steady ? 0 : gap_len();
		@(negedge clk);
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		req_id   <= id;
		do @(posedge clk); while (in_ready !== 1'b1);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (replies_due != 0) @(negedge clk);
	endtask

	// Wait out the chain rebuild that follows every register write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		while (in_ready !== 1'b1) @(negedge clk);
	endtask

	task automatic set_pool(input logic [ID_W-1:0] lo, input logic [ID_W-1:0] hi);
		if ($urandom_range(0, 1)) begin
			write_reg(REG_MIN_ID, lo);
			write_reg(REG_MAX_ID, hi);
		end else begin
			write_reg(REG_MAX_ID, hi);
			write_reg(REG_MIN_ID, lo);
		end
		pool_lo  = lo;
		pool_len = (hi < lo) ? 0 : (((hi - lo) >= DEPTH) ? DEPTH : int'(hi - lo) + 1);
	endtask

	function automatic logic [ID_W-1:0] pick_id();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75 && pool_len > 0)
			return pool_lo + $urandom_range(0, pool_len - 1);
		if (r < 82)
			return pool_lo + pool_len;
		if (r < 88)
			return pool_lo - 1;
		return $urandom();
	endfunction

	function automatic action_t pick_action();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return ACT_ALLOC;
		if (r < 55)
			return ACT_RESERVE;
		if (r < 85)
			return ACT_FREE;
		return ACT_QUERY;
	endfunction

	initial begin
		int g;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
				out_ready <= 1'b1;
			end else begin
				g = rx_steady ? 0 : gap_len();
				if (g == 0) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					repeat (g - 1) @(negedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCH_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [ID_W-1:0] lo;
		logic [ID_W-1:0] hi;
		int size;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// default pool: head, tail, middle and upward predecessor search
		send_item(ACT_ALLOC,   32'd0);
		send_item(ACT_ALLOC,   32'hFFFF_FFFF);
		send_item(ACT_QUERY,   32'd0);
		send_item(ACT_QUERY,   32'd5);
		send_item(ACT_QUERY,   32'd1024);
		send_item(ACT_QUERY,   32'hFFFF_FFFF);
		send_item(ACT_RESERVE, 32'd1);
		send_item(ACT_RESERVE, 32'd1023);
		send_item(ACT_RESERVE, 32'd2);
		send_item(ACT_RESERVE, 32'd500);
		send_item(ACT_FREE,    32'd500);
		send_item(ACT_FREE,    32'd500);
		send_item(ACT_FREE,    32'hFFFF_FFFF);
		send_item(ACT_RESERVE, 32'd1024);
		send_item(ACT_FREE,    32'd1023);
		send_item(ACT_RESERVE, 32'd500);
		drain();

		// two ids at the top of the id space
		set_pool(32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_item(ACT_ALLOC,   32'd0);
		send_item(ACT_RESERVE, 32'hFFFF_FFFF);
		send_item(ACT_ALLOC,   32'd0);
		send_item(ACT_FREE,    32'hFFFF_FFFE);
		send_item(ACT_QUERY,   32'hFFFF_FFFD);
		drain();

		// inverted range
		set_pool(32'd100, 32'd50);
		send_item(ACT_ALLOC,   32'd75);
		send_item(ACT_RESERVE, 32'd75);
		drain();

		// range wider than the table
		set_pool(32'd0, 32'hFFFF_FFFF);
		send_item(ACT_QUERY,   32'd1024);
		send_item(ACT_ALLOC,   32'd0);
		send_item(ACT_FREE,    32'd1023);

		for (int phase = 0; phase < 12; phase++) begin
			drain();
			case (phase % 6)
				3: begin
					lo = $urandom_range(1000, 32'hFFFF_FFFF);
					hi = lo - $urandom_range(1, 999);
				end
				5: begin
					lo = (phase == 5) ? 32'd0 : $urandom_range(0, 32'hFFFF_0000);
					hi = 32'hFFFF_FFFF;
				end
				default: begin
					size = $urandom_range(1, 48);
					case ($urandom_range(0, 2))
						0: lo = $urandom();
						1: lo = $urandom_range(0, 1000);
						default: lo = 32'hFFFF_FFFF - $urandom_range(0, 60);
					endcase
					hi = (lo > 32'hFFFF_FFFF - (size - 1)) ? 32'hFFFF_FFFF : lo + size - 1;
				end
			endcase
			set_pool(lo, hi);
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			if (phase == 1) begin
				hold_req  = 1'b1;
				tx_steady = 1'b1;
			end
			for (int n = 0; n < 45; n++) begin
				if ($urandom_range(0, 39) == 0)
					drain();
				send_item(pick_action(), pick_id());
			end
		end

		drain();
		repeat (50) @(negedge clk);
		if (errors == 0 && replies_due == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/idfl_pkg.sv
rtl/idfl_ram.sv
rtl/idfl_ctrl.sv
rtl/idfl_dp.sv
rtl/id_free_list_allocator_top.sv
rtl/idfl_checker.sv
tb/idfl_checker.sv
tb/tb_top.sv
